[design/evfa_pkg.sv]
// Shared package for the event frame accumulator: codes, defaults and the
// classified event record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evfa_pkg;

    localparam int SIDE_DEF       = 128;
    localparam int BASE_LEVEL_DEF = 125;
    localparam int QUEUE_DEPTH    = 2;

    localparam int      CFG_IDX_W     = 2;
    localparam logic [31:0] ACC_TIME_RST = 32'd10000;
    localparam logic [1:0]  ROTATION_RST = 2'd0;
    localparam logic [7:0]  CONTRAST_RST = 8'd50;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACC_TIME = 2'd0,
        CFG_ROTATION = 2'd1,
        CFG_CONTRAST = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [1:0] {
        POL_ZERO   = 2'd0,
        POL_PLUS   = 2'd1,
        POL_MINUS2 = 2'd2,
        POL_MINUS  = 2'd3
    } t_pol;

    // One classified item; the pixel address travels next to it because its
    // width follows the sensor side.
    typedef struct packed {
        logic        is_read;
        logic        in_range;
        logic [15:0] delta;
        logic [31:0] ev_time;
    } t_evt;

endpackage

`default_nettype wire

[design/event_frame_accumulator_unit.sv]
// Top level of the event frame accumulator: configuration registers and the
// front end, queue and back end. Depends on evfa_pkg, evfa_front,
// evfa_queue and evfa_back.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_ready     command, pos_x, pos_y, polarity,
//                                                   eye, event_time
//  result    out        o_out_valid / i_out_ready   frame_closed, pixel_value
//  config    in         i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// A read, or an event that lands on the sensor, is taken in S_IDLE, where the frame
// bank memory is read, and finished in S_RMW, where an event's updated pixel is written
// back. Events off the sensor and window-closing events give their result from S_IDLE.
// Closing a window swaps the two frame banks and then sweeps the new working bank
// back to the base level, one pixel a cycle. The same sweep clears both banks after
// reset, before the back end takes its first transaction. The front end and a
// two-entry queue keep taking transactions while the back end works or the result
// side stalls.
`timescale 1ns / 1ps
`default_nettype none

module event_frame_accumulator_unit #(
    parameter int SIDE       = evfa_pkg::SIDE_DEF,
    parameter int BASE_LEVEL = evfa_pkg::BASE_LEVEL_DEF,
    localparam int CW        = $clog2(SIDE),
    localparam int AW        = 2 * CW + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [6:0]                    i_pos_x,
    input  wire logic [6:0]                    i_pos_y,
    input  wire logic signed [1:0]             i_polarity,
    input  wire logic                          i_eye,
    input  wire logic [31:0]                   i_event_time,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic                          o_frame_closed,
    output      logic [15:0]                   o_pixel_value,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [evfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    localparam int EW = $bits(evfa_pkg::t_evt);
    localparam int DW = EW + AW;

    // Configuration registers; the user must keep the block idle whenever they change; the block does not enforce it.
    logic [31:0] r_acc_time;
    logic [1:0]  r_rotation;
    logic [7:0]  r_contrast;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_time <= evfa_pkg::ACC_TIME_RST;
            r_rotation <= evfa_pkg::ROTATION_RST;
            r_contrast <= evfa_pkg::CONTRAST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                evfa_pkg::CFG_ACC_TIME: r_acc_time <= i_cfg_data;
                evfa_pkg::CFG_ROTATION: r_rotation <= i_cfg_data[1:0];
                evfa_pkg::CFG_CONTRAST: r_contrast <= i_cfg_data[7:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Front end: decode and address generation into one register stage.
    logic           f_valid;
    logic           f_ready;
    evfa_pkg::t_evt f_evt;
    logic [AW-1:0]  f_addr;

    evfa_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_polarity   (i_polarity),
        .i_eye        (i_eye),
        .i_event_time (i_event_time),
        .i_rotation   (r_rotation),
        .i_contrast   (r_contrast),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_evt        (f_evt),
        .o_addr       (f_addr)
    );

    // Queue between the two halves; each side stalls on its own.
    logic          q_not_empty;
    logic          q_pop;
    logic [DW-1:0] q_data;
    evfa_pkg::t_evt q_evt;
    logic [AW-1:0] q_addr;

    evfa_queue #(
        .DW    (DW),
        .DEPTH (evfa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (f_ready),
        .i_data      ({f_evt, f_addr}),
        .o_not_empty (q_not_empty),
        .i_pop       (q_pop),
        .o_data      (q_data)
    );

    assign q_evt  = evfa_pkg::t_evt'(q_data[DW-1:AW]);
    assign q_addr = q_data[AW-1:0];

    // Back end: window control, frame banks and the result register.
    evfa_back #(
        .SIDE       (SIDE),
        .BASE_LEVEL (BASE_LEVEL)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc_time     (r_acc_time),
        .i_q_valid      (q_not_empty),
        .o_q_pop        (q_pop),
        .i_evt          (q_evt),
        .i_addr         (q_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_closed (o_frame_closed),
        .o_pixel_value  (o_pixel_value)
    );

endmodule

`default_nettype wire

[design/evfa_front.sv]
// Front end: accepts input transactions, rotates coordinates, forms the
// pixel address and the signed increment. Depends on evfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evfa_front #(
    parameter int SIDE = evfa_pkg::SIDE_DEF,
    localparam int CW  = $clog2(SIDE),
    localparam int AW  = 2 * CW + 1
) (
    input  wire                logic         i_clk,
    input  wire                logic         i_rst_n,
    input  wire                logic         i_in_valid,
    output                     logic         o_in_ready,
    input  wire                logic         i_command,
    input  wire                logic [6:0]   i_pos_x,
    input  wire                logic [6:0]   i_pos_y,
    input  wire                logic signed [1:0] i_polarity,
    input  wire                logic         i_eye,
    input  wire                logic [31:0]  i_event_time,
    input  wire                logic [1:0]   i_rotation,
    input  wire                logic [7:0]   i_contrast,
    output                     logic         o_valid,
    input  wire                logic         i_ready,
    output                     evfa_pkg::t_evt o_evt,
    output                     logic [AW-1:0] o_addr
);

    localparam logic [CW-1:0] SIDE_M1 = CW'(SIDE - 1);

    logic           r_valid;
    evfa_pkg::t_evt r_evt;
    logic [AW-1:0]  r_addr;

    logic [CW-1:0]  x_c;
    logic [CW-1:0]  y_c;
    logic [CW-1:0]  nx;
    logic [CW-1:0]  ny;
    logic [15:0]    c16;
    logic [15:0]    delta;
    logic           in_range;
    logic           accept;

    assign x_c      = CW'(i_pos_x);
    assign y_c      = CW'(i_pos_y);
    assign in_range = (32'(i_pos_x) < 32'(SIDE)) && (32'(i_pos_y) < 32'(SIDE));
    assign c16      = 16'(i_contrast);

    always_comb begin
        case (i_rotation)
            evfa_pkg::ROT_90: begin
                nx = y_c;
                ny = SIDE_M1 - x_c;
            end
            evfa_pkg::ROT_180: begin
                nx = SIDE_M1 - x_c;
                ny = SIDE_M1 - y_c;
            end
            evfa_pkg::ROT_270: begin
                nx = SIDE_M1 - y_c;
                ny = x_c;
            end
            default: begin
                nx = x_c;
                ny = y_c;
            end
        endcase
    end

    always_comb begin
        case (i_polarity)
            evfa_pkg::POL_PLUS:   delta = c16;
            evfa_pkg::POL_MINUS2: delta = 16'd0 - (c16 << 1);
            evfa_pkg::POL_MINUS:  delta = 16'd0 - c16;
            default:              delta = 16'd0;
        endcase
    end

    assign o_in_ready = !r_valid || i_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Reads address the published frame unrotated; events use the rotated spot.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_evt.is_read  <= (i_command == evfa_pkg::CMD_READ);
            r_evt.in_range <= in_range;
            r_evt.delta    <= delta;
            r_evt.ev_time  <= i_event_time;
            if (i_command == evfa_pkg::CMD_READ) begin
                r_addr <= {i_eye, y_c, x_c};
            end else begin
                r_addr <= {i_eye, ny, nx};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;
    assign o_addr  = r_addr;

endmodule

`default_nettype wire

[design/evfa_queue.sv]
// Small first-in first-out queue that decouples the front and back ends.
// Depends on evfa_pkg for its default depth.
`timescale 1ns / 1ps
`default_nettype none

module evfa_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = evfa_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output      logic          o_not_full,
    input  wire logic [DW-1:0] i_data,
    output      logic          o_not_empty,
    input  wire logic          i_pop,
    output      logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_not_full  = (r_cnt != (PW+1)'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign push_ok     = i_push && o_not_full;
    assign pop_ok      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[design/evfa_back.sv]
// Back end: window tracking, two swapped frame banks with read-modify-write,
// bank clearing sweep and the result register. Depends on evfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evfa_back #(
    parameter int SIDE       = evfa_pkg::SIDE_DEF,
    parameter int BASE_LEVEL = evfa_pkg::BASE_LEVEL_DEF,
    localparam int CW        = $clog2(SIDE),
    localparam int AW        = 2 * CW + 1,
    localparam int DEPTH     = 1 << AW
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [31:0]    i_acc_time,
    input  wire logic           i_q_valid,
    output      logic           o_q_pop,
    input  wire evfa_pkg::t_evt i_evt,
    input  wire logic [AW-1:0]  i_addr,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    output      logic           o_frame_closed,
    output      logic [15:0]    o_pixel_value
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW
    } t_state;

    t_state        r_state;
    logic          r_pub;
    logic          r_pending;
    logic [31:0]   r_ws;
    logic [AW-1:0] r_clr_cnt;
    logic          r_clr_both;
    logic          r_clr_bank;
    logic          r_out_valid;
    logic          r_out_closed;
    logic [15:0]   r_out_pixel;
    logic          r_op_read;
    logic          r_op_bank;
    logic [AW-1:0] r_op_addr;
    logic [15:0]   r_op_delta;

    logic [15:0]   r_mem0 [DEPTH];
    logic [15:0]   r_mem1 [DEPTH];
    logic [15:0]   r_rd0;
    logic [15:0]   r_rd1;

    logic [32:0]   win_end;
    logic          in_win;
    logic          out_free;
    logic          take;
    logic          closing;
    logic [15:0]   rdata;
    logic          we0;
    logic          we1;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;

    assign win_end  = {1'b0, r_ws} + {1'b0, i_acc_time};
    assign in_win   = win_end > {1'b0, i_evt.ev_time};
    assign out_free = !r_out_valid || i_out_ready;
    assign take     = (r_state == S_IDLE) && i_q_valid && out_free;
    assign closing  = take && !i_evt.is_read && !r_pending && !in_win;
    assign o_q_pop  = take;
    assign rdata    = r_op_bank ? r_rd1 : r_rd0;

    always_comb begin
        we0   = 1'b0;
        we1   = 1'b0;
        waddr = r_op_addr;
        wdata = rdata + r_op_delta;
        if (r_state == S_CLEAR) begin
            waddr = r_clr_cnt;
            wdata = 16'(BASE_LEVEL);
            we0   = r_clr_both || !r_clr_bank;
            we1   = r_clr_both || r_clr_bank;
        end else if ((r_state == S_RMW) && !r_op_read) begin
            we0 = !r_op_bank;
            we1 = r_op_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[waddr] <= wdata;
        end
        r_rd0 <= r_mem0[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[waddr] <= wdata;
        end
        r_rd1 <= r_mem1[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pub       <= 1'b0;
            r_pending   <= 1'b1;
            r_ws        <= '0;
            r_clr_cnt   <= '0;
            r_clr_both  <= 1'b1;
            r_clr_bank  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == '1) begin
                        r_clr_both <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_op_read  <= i_evt.is_read;
                        r_op_addr  <= i_addr;
                        r_op_delta <= i_evt.delta;
                        r_op_bank  <= i_evt.is_read ? r_pub : !r_pub;
                        if (closing) begin
                            r_pub        <= !r_pub;
                            r_pending    <= 1'b1;
                            r_clr_bank   <= r_pub;
                            r_clr_cnt    <= '0;
                            r_out_valid  <= 1'b1;
                            r_out_closed <= 1'b1;
                            r_out_pixel  <= '0;
                            r_state      <= S_CLEAR;
                        end else begin
                            if (!i_evt.is_read && r_pending) begin
                                r_ws      <= i_evt.ev_time;
                                r_pending <= 1'b0;
                            end
                            if (i_evt.in_range) begin
                                r_state <= S_RMW;
                            end else begin
                                r_out_valid  <= 1'b1;
                                r_out_closed <= 1'b0;
                                r_out_pixel  <= '0;
                            end
                        end
                    end
                end
                S_RMW: begin
                    r_out_valid  <= 1'b1;
                    r_out_closed <= 1'b0;
                    r_out_pixel  <= r_op_read ? rdata : 16'd0;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_closed = r_out_closed;
    assign o_pixel_value  = r_out_pixel;

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("queue popped during a bank sweep");

    a_close_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        closing |=> (r_state == S_CLEAR) && r_pending && r_out_valid && r_out_closed)
        else $error("closing a window did not start a sweep");

    a_swap_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pub != $past(r_pub)) |-> (r_out_valid && r_out_closed))
        else $error("banks swapped without a closing result");

    a_rmw_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> !r_out_valid)
        else $error("result register busy while a pixel result is due");

endmodule

`default_nettype wire
